/* rtl/core/lap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lap_pkg
// shared constants, widths and the arctangent table of the phaser core
// ----------------------------------------------------------------------------
package lap_pkg;

    // default module parameters
    localparam int DEF_STAGES       = 4;
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_PHASE_WIDTH  = 32;

    // unit widths
    localparam int MUL_A_W      = 33;
    localparam int MUL_LO_W     = 17;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_N_W      = 64;
    localparam int DIV_D_W      = 32;

    // configuration register indexes
    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_TRIM  = 2'd1;
    localparam logic [1:0] REG_RATE  = 2'd2;

    localparam logic [15:0] SPEED_RESET = 16'd32768;
    localparam logic [15:0] TRIM_RESET  = 16'd32768;
    localparam logic [17:0] RATE_RESET  = 18'd48000;
    localparam logic [17:0] FS_MIN      = 18'd8000;
    localparam logic [17:0] FS_MAX      = 18'd192000;

    // fixed point constants
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [18:0] LOG2_RATIO_Q16 = 19'd479850;
    localparam logic [19:0] MIN_RATE_Q24   = 20'd838861;
    localparam logic [29:0] POW_C1         = 30'd746357942;
    localparam logic [29:0] POW_C2         = 30'd242880401;
    localparam logic [29:0] POW_C3         = 30'd84503482;
    localparam logic [29:0] DEPTH_BASE     = 30'd268435456;
    localparam logic [29:0] DEPTH_SPAN     = 30'd805306368;
    localparam logic [29:0] MIX_BASE       = 30'd375809638;
    localparam logic [29:0] MIX_SPAN       = 30'd483183821;
    localparam logic [26:0] SWEEP_BASE_Q16 = 27'd11796480;
    localparam logic [10:0] SWEEP_SPAN_HZ  = 11'd1620;
    localparam logic [31:0] PI_Q30         = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [29:0] CORDIC_K       = 30'd652032875;

    // atan(2^-i) in q30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:  return 30'd843314857;
            5'd1:  return 30'd497837829;
            5'd2:  return 30'd263043837;
            5'd3:  return 30'd133525159;
            5'd4:  return 30'd67021687;
            5'd5:  return 30'd33543516;
            5'd6:  return 30'd16775851;
            5'd7:  return 30'd8388437;
            5'd8:  return 30'd4194283;
            5'd9:  return 30'd2097149;
            5'd10: return 30'd1048576;
            5'd11: return 30'd524288;
            5'd12: return 30'd262144;
            5'd13: return 30'd131072;
            5'd14: return 30'd65536;
            5'd15: return 30'd32768;
            5'd16: return 30'd16384;
            5'd17: return 30'd8192;
            5'd18: return 30'd4096;
            5'd19: return 30'd2048;
            5'd20: return 30'd1024;
            5'd21: return 30'd512;
            5'd22: return 30'd256;
            5'd23: return 30'd128;
            5'd24: return 30'd64;
            5'd25: return 30'd32;
            5'd26: return 30'd16;
            5'd27: return 30'd8;
            5'd28: return 30'd4;
            5'd29: return 30'd2;
            default: return 30'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lap_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lap_mul
// signed multiplier, low and high partial products one after the other
// ----------------------------------------------------------------------------
module lap_mul #(
    parameter int B_WIDTH = 34
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_start,
    input  wire logic signed [lap_pkg::MUL_A_W-1:0]          i_a,
    input  wire logic signed [B_WIDTH-1:0]                   i_b,
    output logic                                             o_done,
    output logic signed [lap_pkg::MUL_A_W+B_WIDTH-1:0]       o_prod
);
    import lap_pkg::*;

    localparam int HI_W = B_WIDTH - MUL_LO_W;
    localparam int PW   = MUL_A_W + B_WIDTH;

    logic signed [MUL_A_W-1:0]        r_a;
    logic signed [MUL_LO_W:0]         r_b_lo;
    logic signed [HI_W-1:0]           r_b_hi;
    logic signed [PW-1:0]             r_acc;
    logic                             r_busy;
    logic                             r_second;
    logic                             r_done;
    logic signed [MUL_A_W+MUL_LO_W:0] w_lo;
    logic signed [MUL_A_W+HI_W-1:0]   w_hi;

    assign w_lo = r_a * r_b_lo;
    assign w_hi = r_a * r_b_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a      <= i_a;
                r_b_lo   <= $signed({1'b0, i_b[MUL_LO_W-1:0]});
                r_b_hi   <= i_b[B_WIDTH-1:MUL_LO_W];
                r_busy   <= 1'b1;
                r_second <= 1'b0;
            end else if (r_busy && !r_second) begin
                r_acc    <= PW'(w_lo);
                r_second <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= r_acc + (PW'(w_hi) <<< MUL_LO_W);
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

/* rtl/core/lap_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lap_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lap_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lap_pkg::DIV_N_W-1:0]   i_dividend,
    input  wire logic [lap_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [lap_pkg::DIV_N_W-1:0]        o_quotient
);
    import lap_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_fits;

    assign w_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* rtl/core/lap_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lap_cordic
// rotation mode cordic, one micro-rotation per cycle, cosine and sine in q30
// ----------------------------------------------------------------------------
module lap_cordic (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [lap_pkg::CORDIC_W-1:0] i_angle,
    output logic                                     o_done,
    output logic signed [lap_pkg::CORDIC_W-1:0]      o_cos,
    output logic signed [lap_pkg::CORDIC_W-1:0]      o_sin
);
    import lap_pkg::*;

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic [4:0]                 r_step;
    logic                       r_busy;
    logic                       r_done;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [CORDIC_W-1:0] w_at;

    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_at = $signed(CORDIC_W'(atan_q30(r_step)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= $signed(CORDIC_W'(CORDIC_K));
                r_y    <= '0;
                r_z    <= i_angle;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[CORDIC_W-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_step <= r_step + 1'b1;
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule
`default_nettype wire

/* rtl/core/lfo_allpass_phaser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_allpass_phaser_unit
// sine lfo swept allpass phaser with dry/wet mix, one sample at a time
// ----------------------------------------------------------------------------
// Each accepted input word is one signed audio sample; one mixed, saturated
// sample comes out for it. The block works on one sample at a time and holds
// o_in_ready low until the result of that sample is loaded into the output
// register. Three 64-step restoring divisions (lfo step, sweep angle,
// allpass coefficient), two 30-step cordic rotations and passes through the
// shared two-part multiplier make up the work on a sample. A result waits in
// the output register, so a slow consumer only stalls the block when the
// next result is ready. The user must write registers through the apb port
// only while the block is idle; the block itself does not enforce this:
// speed at 0x0, trimmer at 0x4, sample rate at 0x8.
// ----------------------------------------------------------------------------
module lfo_allpass_phaser_unit #(
    parameter int STAGES       = lap_pkg::DEF_STAGES,
    parameter int SAMPLE_WIDTH = lap_pkg::DEF_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH  = lap_pkg::DEF_PHASE_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_audio_in,
    // sample output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_audio_out,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [3:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import lap_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int GW     = SAMPLE_WIDTH + 8;   // stage output with guard bits
    localparam int DW     = SAMPLE_WIDTH + 9;   // stage difference
    localparam int MB     = (DW > 34) ? DW : 34;
    localparam int PW_M   = MUL_A_W + MB;
    localparam int PSH    = 32 - PHASE_WIDTH;
    localparam int INC_SH = 54 - PHASE_WIDTH;
    localparam int SIDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CW     = CORDIC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_HOLD
    } t_state;

    // micro-operation sequence of one sample
    typedef enum logic [4:0] {
        OP_EXP,     // speed * log2(160)
        OP_P3,      // 2^f polynomial, innermost term
        OP_P2,
        OP_P1,
        OP_RATE,    // 2^f * 0.05, then the integer shift
        OP_DIVR,    // rate / fs -> phase step
        OP_DEPTH,
        OP_MIX,
        OP_ANG,     // folded phase * pi/2
        OP_COR1,    // lfo sine
        OP_LD,      // depth * lfo
        OP_SWP,     // sweep in q16 hz
        OP_SPI,     // sweep * pi
        OP_DIVA,    // / fs -> angle
        OP_COR2,    // tan via cos and sin
        OP_DIVC,    // (c - s) / (c + s)
        OP_STG,     // one allpass stage, repeated
        OP_OUT      // dry/wet mix
    } t_op;

    // configuration
    logic [15:0] r_speed;
    logic [15:0] r_trim;
    logic [17:0] r_fs_reg;
    logic [17:0] w_fs;
    logic        w_cfg_wr;

    // sequencer
    t_state r_state;
    t_op    r_op;
    logic [SIDX_W-1:0] r_stage;

    // filter and lfo state
    logic [PHASE_WIDTH-1:0]   r_phase;
    logic signed [SW-1:0]     r_prev_in  [STAGES];
    logic signed [GW-1:0]     r_prev_out [STAGES];

    // working registers
    logic [2:0]               r_ip;
    logic [29:0]              r_f;
    logic [31:0]              r_acc;
    logic [63:0]              r_rate;
    logic [PHASE_WIDTH-1:0]   r_inc;
    logic [30:0]              r_depth;
    logic [30:0]              r_mix;
    logic signed [CW-1:0]     r_z;
    logic [30:0]              r_lfo;
    logic [30:0]              r_ld;
    logic [26:0]              r_sweep;
    logic [31:0]              r_num;
    logic [31:0]              r_den;
    logic [30:0]              r_a;
    logic signed [SW-1:0]     r_dry;
    logic signed [SW-1:0]     r_x;
    logic signed [GW-1:0]     r_y;
    logic signed [SW-1:0]     r_res;
    logic signed [SW-1:0]     r_out;
    logic                     r_out_valid;

    // shared unit hookup
    logic                       w_is_div;
    logic                       w_is_cor;
    logic                       w_mul_start;
    logic                       w_div_start;
    logic                       w_cor_start;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MB-1:0]       w_mul_b;
    logic                       w_mul_done;
    logic signed [PW_M-1:0]     w_mul_prod;
    logic [DIV_N_W-1:0]         w_div_n;
    logic [DIV_D_W-1:0]         w_div_d;
    logic                       w_div_done;
    logic [DIV_N_W-1:0]         w_div_q;
    logic                       w_cor_done;
    logic signed [CW-1:0]       w_cor_cos;
    logic signed [CW-1:0]       w_cor_sin;
    logic                       w_unit_done;

    // derived values
    logic [31:0]                w_p32;
    logic signed [32:0]         w_pr;
    logic signed [PW_M-1:0]     w_half;
    logic signed [PW_M-1:0]     w_round;
    logic signed [PW_M-1:0]     w_q30;
    logic signed [CW-1:0]       w_lfo_sum;
    logic signed [CW-1:0]       w_lfo_half;
    logic [30:0]                w_lfo;
    logic signed [CW:0]         w_num;
    logic signed [CW:0]         w_den;
    logic signed [PW_M-1:0]     w_stage_sum;
    logic signed [GW-1:0]       w_stage_y;
    logic signed [PW_M-1:0]     w_mix_sum;

    function automatic logic signed [GW-1:0] sat_guard(input logic signed [PW_M-1:0] v);
        if (v[PW_M-1:GW-1] == {(PW_M-GW+1){v[PW_M-1]}})
            return v[GW-1:0];
        else if (v[PW_M-1])
            return {1'b1, {(GW-1){1'b0}}};
        else
            return {1'b0, {(GW-1){1'b1}}};
    endfunction

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [PW_M-1:0] v);
        if (v[PW_M-1:SW-1] == {(PW_M-SW+1){v[PW_M-1]}})
            return v[SW-1:0];
        else if (v[PW_M-1])
            return {1'b1, {(SW-1){1'b0}}};
        else
            return {1'b0, {(SW-1){1'b1}}};
    endfunction

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SPEED_RESET;
            r_trim   <= TRIM_RESET;
            r_fs_reg <= RATE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_SPEED: r_speed  <= pwdata[15:0];
                REG_TRIM:  r_trim   <= pwdata[15:0];
                REG_RATE:  r_fs_reg <= pwdata[17:0];
                default:   ;    // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED: prdata = {16'd0, r_speed};
            REG_TRIM:  prdata = {16'd0, r_trim};
            REG_RATE:  prdata = {14'd0, r_fs_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // sample rate clamp
    assign w_fs = (r_fs_reg < FS_MIN) ? FS_MIN : ((r_fs_reg > FS_MAX) ? FS_MAX : r_fs_reg);

    // ---------------- lfo phase fold ----------------
    // fold the phase into -1/4..1/4 of the lfo period so the cordic sees at most pi/2
    assign w_p32 = 32'(r_phase) << PSH;

    always_comb begin
        case (w_p32[31:30]) inside
            2'b01, 2'b10: w_pr = $signed(33'h0_8000_0000 - {1'b0, w_p32});
            2'b11:        w_pr = $signed({1'b1, w_p32});
            default:      w_pr = $signed({1'b0, w_p32});
        endcase
    end

    // ---------------- unit selection ----------------
    always_comb begin
        case (r_op) inside
            OP_DIVR, OP_DIVA, OP_DIVC: w_is_div = 1'b1;
            default:                   w_is_div = 1'b0;
        endcase
        case (r_op) inside
            OP_COR1, OP_COR2: w_is_cor = 1'b1;
            default:          w_is_cor = 1'b0;
        endcase
    end

    assign w_mul_start = (r_state == ST_ISSUE) && !w_is_div && !w_is_cor;
    assign w_div_start = (r_state == ST_ISSUE) && w_is_div;
    assign w_cor_start = (r_state == ST_ISSUE) && w_is_cor;
    assign w_unit_done = w_is_div ? w_div_done : (w_is_cor ? w_cor_done : w_mul_done);

    // multiplier operands per step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_op)
            OP_EXP: begin
                w_mul_a = MUL_A_W'(LOG2_RATIO_Q16);
                w_mul_b = MB'(r_speed);
            end
            OP_P3: begin
                w_mul_a = MUL_A_W'(POW_C3);
                w_mul_b = MB'(r_f);
            end
            OP_P2, OP_P1: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = MB'(r_f);
            end
            OP_RATE: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = MB'(MIN_RATE_Q24);
            end
            OP_DEPTH: begin
                w_mul_a = MUL_A_W'(DEPTH_SPAN);
                w_mul_b = MB'(r_trim);
            end
            OP_MIX: begin
                w_mul_a = MUL_A_W'(MIX_SPAN);
                w_mul_b = MB'(r_trim);
            end
            OP_ANG: begin
                w_mul_a = MUL_A_W'(HALF_PI_Q30);
                w_mul_b = MB'(w_pr);
            end
            OP_LD: begin
                w_mul_a = MUL_A_W'(r_depth);
                w_mul_b = MB'(r_lfo);
            end
            OP_SWP: begin
                w_mul_a = MUL_A_W'(SWEEP_SPAN_HZ);
                w_mul_b = MB'(r_ld);
            end
            OP_SPI: begin
                w_mul_a = MUL_A_W'(PI_Q30);
                w_mul_b = MB'(r_sweep);
            end
            OP_STG: begin
                w_mul_a = MUL_A_W'(r_a);
                w_mul_b = MB'(DW'(r_x) - DW'(r_prev_out[r_stage]));
            end
            OP_OUT: begin
                w_mul_a = MUL_A_W'(r_mix);
                w_mul_b = MB'(DW'(r_y) - DW'(r_dry));
            end
            default: ;
        endcase
    end

    // divider operands: both fs divisions reuse r_rate as dividend
    assign w_div_n = (r_op == OP_DIVC) ? (64'(r_num) << 30) : r_rate;
    assign w_div_d = (r_op == OP_DIVC) ? r_den : 32'(w_fs);

    // ---------------- result shaping ----------------
    // q30 product rounded half up
    assign w_half  = {{(PW_M-30){1'b0}}, 1'b1, 29'd0};
    assign w_round = w_mul_prod + w_half;
    assign w_q30   = w_round >>> 30;

    // lfo = (1 + sin) / 2, clamped to 0..1
    assign w_lfo_sum  = $signed(CW'(ONE_Q30)) + w_cor_sin;
    assign w_lfo_half = w_lfo_sum >>> 1;
    always_comb begin
        if (w_lfo_half[CW-1])
            w_lfo = '0;
        else if (w_lfo_half > $signed(CW'(ONE_Q30)))
            w_lfo = ONE_Q30;
        else
            w_lfo = w_lfo_half[30:0];
    end

    assign w_num = (CW+1)'(w_cor_cos) - (CW+1)'(w_cor_sin);
    assign w_den = (CW+1)'(w_cor_cos) + (CW+1)'(w_cor_sin);

    assign w_stage_sum = w_q30 + PW_M'(r_prev_in[r_stage]);
    assign w_stage_y   = sat_guard(w_stage_sum);
    assign w_mix_sum   = PW_M'(r_dry) + w_q30;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_EXP;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            for (int i = 0; i < STAGES; i++) begin
                r_prev_in[i]  <= '0;
                r_prev_out[i] <= '0;
            end
        end else begin
            // the hold state reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != ST_HOLD))
                r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_dry   <= i_audio_in;
                        r_x     <= i_audio_in;
                        r_stage <= '0;
                        r_op    <= OP_EXP;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_unit_done) begin
                        r_state <= ST_ISSUE;
                        case (r_op)
                            OP_EXP: begin
                                r_ip <= w_mul_prod[34:32];
                                r_f  <= w_mul_prod[31:2];
                                r_op <= OP_P3;
                            end
                            OP_P3: begin
                                r_acc <= 32'(POW_C2) + w_q30[31:0];
                                r_op  <= OP_P2;
                            end
                            OP_P2: begin
                                r_acc <= 32'(POW_C1) + w_q30[31:0];
                                r_op  <= OP_P1;
                            end
                            OP_P1: begin
                                r_acc <= 32'(ONE_Q30) + w_q30[31:0];
                                r_op  <= OP_RATE;
                            end
                            OP_RATE: begin
                                r_rate <= w_mul_prod[63:0] << r_ip;
                                r_op   <= OP_DIVR;
                            end
                            OP_DIVR: begin
                                r_inc <= PHASE_WIDTH'(w_div_q >> INC_SH);
                                r_op  <= OP_DEPTH;
                            end
                            OP_DEPTH: begin
                                r_depth <= 31'(DEPTH_BASE) + w_mul_prod[46:16];
                                r_op    <= OP_MIX;
                            end
                            OP_MIX: begin
                                r_mix <= 31'(MIX_BASE) + w_mul_prod[46:16];
                                r_op  <= OP_ANG;
                            end
                            OP_ANG: begin
                                r_z  <= w_q30[CW-1:0];
                                r_op <= OP_COR1;
                            end
                            OP_COR1: begin
                                r_lfo <= w_lfo;
                                r_op  <= OP_LD;
                            end
                            OP_LD: begin
                                r_ld <= w_q30[30:0];
                                r_op <= OP_SWP;
                            end
                            OP_SWP: begin
                                r_sweep <= SWEEP_BASE_Q16 + w_mul_prod[40:14];
                                r_op    <= OP_SPI;
                            end
                            OP_SPI: begin
                                r_rate <= w_mul_prod[63:0];
                                r_op   <= OP_DIVA;
                            end
                            OP_DIVA: begin
                                r_z  <= CW'(w_div_q[63:16]);
                                r_op <= OP_COR2;
                            end
                            OP_COR2: begin
                                r_num <= w_num[CW] ? 32'd0 : w_num[31:0];
                                r_den <= (w_den[CW] || (w_den == '0)) ? 32'd1 : w_den[31:0];
                                r_op  <= OP_DIVC;
                            end
                            OP_DIVC: begin
                                // coefficient clamped to one
                                r_a  <= (w_div_q > 64'(ONE_Q30)) ? ONE_Q30 : w_div_q[30:0];
                                r_op <= OP_STG;
                            end
                            OP_STG: begin
                                r_prev_in[r_stage]  <= r_x;
                                r_prev_out[r_stage] <= w_stage_y;
                                r_y                 <= w_stage_y;
                                r_x                 <= sat_sample(PW_M'(w_stage_y));
                                if (r_stage == SIDX_W'(STAGES - 1)) begin
                                    r_op <= OP_OUT;
                                end else begin
                                    r_stage <= r_stage + 1'b1;
                                end
                            end
                            OP_OUT: begin
                                r_res   <= sat_sample(w_mix_sum);
                                r_phase <= r_phase + r_inc;
                                r_state <= ST_HOLD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_HOLD: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_out;

    // ---------------- shared units ----------------
    lap_mul #(
        .B_WIDTH (MB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    lap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    lap_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (r_z),
        .o_done  (w_cor_done),
        .o_cos   (w_cor_cos),
        .o_sin   (w_cor_sin)
    );

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lfo swept allpass phaser unit
// ----------------------------------------------------------------------------
// Audio words go in through a bursty sender, and results drain through a
// receiver that stalls on its own pattern. A bit-true fixed-point model of
// the lfo, the coefficient path, the allpass cascade and the mix predicts
// every output word. Registers are changed only once the block has gone idle.
// ----------------------------------------------------------------------------
module tb;
    import lap_pkg::*;

    // latency of one word at four stages, plus margin
    localparam int DRAIN_CYCLES = 360;
    localparam int WATCHDOG_MAX = 6000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint Q30      = 64'd1073741824;
    localparam longint SAT_LIM  = 64'd8388607;
    localparam longint WIDE_LIM = 64'd2147483647;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [23:0] i_audio_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [23:0] o_audio_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lfo_allpass_phaser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_audio_in  (i_audio_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_audio_out (o_audio_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // phaser model state
    // ------------------------------------------------------------------
    logic [15:0] mdl_speed;
    logic [15:0] mdl_trim;
    logic [17:0] mdl_rate;
    logic [31:0] mdl_phase;
    longint      mdl_prev_in  [4];
    longint      mdl_prev_out [4];

    logic signed [23:0] phased_q[$];
    int                 fail_count;
    int                 burst_left;

    longint atan_tab [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    // round(a*v / 2^30) done as two partial products
    function automatic longint q30_mul(longint a, longint v);
        longint hi;
        longint lo;
        longint t;
        hi = v >>> 16;
        lo = v - hi * 65536;
        t  = a * hi + ((a * lo) >>> 16);
        return (t + 8192) >>> 14;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    task automatic rotate(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 64'd652032875;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        c = x;
        s = y;
    endtask

    // advances the model by one sample and returns the mixed word
    task automatic phase_sample(input logic signed [23:0] smp,
                                output logic signed [23:0] res);
        longint fs, e, f, p, rate, step, depth, mix, pr, c, s, lfo;
        longint ld, sweep, angle, num, den, a, x, y, dry;
        int ip;
        fs = mdl_rate < 18'd8000 ? 8000 : (mdl_rate > 18'd192000 ? 192000 : mdl_rate);

        e  = longint'(mdl_speed) * 479850;
        ip = int'((e >> 32) & 7);
        f  = (e & 64'hFFFF_FFFF) >> 2;
        p  = Q30 + q30_mul(f, 746357942 + q30_mul(f, 242880401 + q30_mul(f, 84503482)));
        rate = (p << ip) * 838861;
        step = (rate / fs) >> 22;

        depth = 268435456 + ((longint'(mdl_trim) * 805306368) >>> 16);
        mix   = 375809638 + ((longint'(mdl_trim) * 483183821) >>> 16);

        // fold the phase into -1/4..1/4 of the lfo period
        if (mdl_phase >= 32'h4000_0000 && mdl_phase < 32'hC000_0000)
            pr = 64'h8000_0000 - longint'(mdl_phase);
        else if (mdl_phase >= 32'hC000_0000)
            pr = longint'(mdl_phase) - 64'h1_0000_0000;
        else
            pr = longint'(mdl_phase);
        rotate(q30_mul(1686629713, pr), c, s);
        lfo = (Q30 + s) >>> 1;
        if (lfo < 0) lfo = 0;
        if (lfo > Q30) lfo = Q30;

        ld    = q30_mul(depth, lfo);
        sweep = (64'd180 << 16) + ((1620 * ld) >>> 14);
        angle = ((sweep * 64'd3373259426) / fs) >>> 16;
        rotate(angle, c, s);
        num = c - s;
        den = c + s;
        if (num < 0) num = 0;
        if (den <= 0) den = 1;
        a = (num * Q30) / den;
        if (a > Q30) a = Q30;

        dry = longint'(smp);
        x = dry;
        y = 0;
        for (int i = 0; i < 4; i++) begin
            y = clip(q30_mul(a, x - mdl_prev_out[i]) + mdl_prev_in[i], WIDE_LIM);
            mdl_prev_in[i]  = x;
            mdl_prev_out[i] = y;
            x = clip(y, SAT_LIM);
        end
        res = 24'(clip(dry + q30_mul(mix, y - dry), SAT_LIM));
        mdl_phase = mdl_phase + 32'(step);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of words with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_word(input logic signed [23:0] smp);
        logic signed [23:0] res;
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_audio_in <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        phase_sample(smp, res);
        phased_q.push_back(res);
    endtask

    // lowers valid and waits until every word is out and the block is idle
    task automatic drain;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (phased_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SPEED: mdl_speed = val[15:0];
            REG_TRIM:  mdl_trim  = val[15:0];
            REG_RATE:  mdl_rate  = val[17:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // all three registers in turn, then readback
    task automatic set_knobs(input logic [31:0] spd, input logic [31:0] trm,
                             input logic [31:0] fs);
        reg_write(REG_SPEED, spd);
        reg_write(REG_TRIM, trm);
        reg_write(REG_RATE, fs);
        reg_check(REG_SPEED, {16'd0, spd[15:0]});
        reg_check(REG_TRIM, {16'd0, trm[15:0]});
        reg_check(REG_RATE, {14'd0, fs[17:0]});
    endtask

    function automatic logic signed [23:0] rand_sample;
        case ($urandom_range(0, 7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 255)) - 24'sd128;
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, alternating and single-bit patterns at reset settings
    task automatic test_sample_extremes;
        logic signed [23:0] pat [10] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000,
            24'shFFFFFF, 24'sh555555, 24'shAAAAAA, 24'sh000001, 24'sh400000,
            24'shC00000, 24'sh7FFFFF};
        foreach (pat[i]) send_word(pat[i]);
        drain();
    endtask

    // full-scale square wave with a low corner drives the stage clamps
    task automatic test_stage_overflow;
        set_knobs(32'd65535, 32'd0, 32'd8000);
        for (int i = 0; i < 8; i++) send_word(i[0] ? 24'sh800000 : 24'sh7FFFFF);
        drain();
    endtask

    // rates outside the legal range clamp, stray bits and unused address ignored
    task automatic test_rate_clamp;
        set_knobs(32'hFFFF_0000, 32'hABCD_FFFF, 32'd0);
        send_word(24'sh7FFFFF);
        send_word(24'sh800000);
        drain();
        set_knobs(32'd1, 32'd65535, 32'hFFFF_FFFF);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(24'sh123456);
        send_word(24'shEDCBA9);
        drain();
        set_knobs(32'd0, 32'd32768, 32'd7999);
        send_word(24'sh7FFFFF);
        drain();
        set_knobs(32'd40000, 32'd100, 32'd192001);
        send_word(24'sh800000);
        drain();
    endtask

    // random settings per phase, extremes among them, random audio
    task automatic test_random_phases;
        logic [31:0] spd, trm, fs;
        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: begin spd = 65535; trm = 65535; fs = 8000; end
                1: begin spd = 0; trm = 0; fs = 192000; end
                2: begin spd = 65535; trm = 0; fs = 44100; end
                default: begin
                    spd = $urandom;
                    trm = $urandom;
                    fs = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(8000, 192000);
                end
            endcase
            set_knobs(spd, trm, fs);
            repeat (48) send_word(rand_sample());
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver with its own stall pattern, and the result check
    // ------------------------------------------------------------------
    int stall_left;
    int stall_mode;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (phased_q.size() == 0) begin
                $error("audio_out: unexpected word %0d", o_audio_out);
                fail_count++;
            end else begin
                logic signed [23:0] want;
                want = phased_q.pop_front();
                if (o_audio_out !== want) begin
                    $error("audio_out: expected %0d, got %0d", want, o_audio_out);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 7);
            stall_left = stall_mode == 0 ? $urandom_range(300, 700) : $urandom_range(20, 200);
        end
        stall_left--;
        // long hold, free run, or a choppy pattern
        if (stall_mode == 0)
            i_out_ready <= 1'b0;
        else if (stall_mode < 3)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 2) != 0);
    end

    // watchdog on cycles without any handshake
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_mode  = 1;
        idle_cycles = 0;
        mdl_speed = SPEED_RESET;
        mdl_trim  = TRIM_RESET;
        mdl_rate  = RATE_RESET;
        mdl_phase = '0;
        for (int i = 0; i < 4; i++) begin
            mdl_prev_in[i]  = 0;
            mdl_prev_out[i] = 0;
        end
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_audio_in <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_stage_overflow();
        test_rate_clamp();
        test_random_phases();

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lap_pkg.sv
rtl/core/lap_mul.sv
rtl/core/lap_div.sv
rtl/core/lap_cordic.sv
rtl/core/lfo_allpass_phaser_unit.sv
sim/tb.sv
